// ===== rtl/door_safety_state_machine_assert.svh =====
// assertion macros for the door safety state machine
// depends on nothing; pulled in by the top level with an include
`ifndef DOOR_SAFETY_STATE_MACHINE_ASSERT_SVH
`define DOOR_SAFETY_STATE_MACHINE_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define DSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("door safety assertion failed");

// next-cycle implication, quiet while in reset
`define DSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("door safety assertion failed");

`endif

// ===== rtl/dss_pkg.sv =====
// shared types and codes for the door safety state machine
// depends on nothing
`default_nettype none

package dss_pkg;

  // motion frame counter width
  localparam int FRAME_COUNT_WIDTH = 16;

  localparam int TIMEOUT_W = 16;
  localparam int RETRY_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [RETRY_W-1:0] RETRY_MAX = 4'd15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUDGE_LIMIT    = 2'd1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;
  localparam logic [RETRY_W-1:0]   NUDGE_RESET   = 4'd3;

  typedef enum logic [2:0] {
    CMD_HOLD_CLOSED = 3'd0,
    CMD_DRIVE_OPEN  = 3'd1,
    CMD_HOLD_OPEN   = 3'd2,
    CMD_DRIVE_CLOSE = 3'd3,
    CMD_NUDGE_CLOSE = 3'd4,
    CMD_LATCH_FAULT = 3'd5,
    CMD_RESET       = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    FLT_NONE    = 2'd0,
    FLT_TIMEOUT = 2'd1,
    FLT_LOCK    = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    POS_BETWEEN = 2'd0,
    POS_OPEN    = 2'd1,
    POS_CLOSED  = 2'd2
  } pos_t;

  typedef enum logic [1:0] {
    MOTOR_STOP  = 2'd0,
    MOTOR_OPEN  = 2'd1,
    MOTOR_CLOSE = 2'd2
  } motor_t;

  // live configuration
  typedef struct packed {
    logic [TIMEOUT_W-1:0] motion_timeout_frames;
    logic [RETRY_W-1:0]   nudge_retry_limit;
  } cfg_t;

  // one control frame
  typedef struct packed {
    logic open_feedback;
    logic closed_feedback;
    logic lock_sense;
    logic reset_req;
    logic open_req;
    logic close_req;
    logic obstruction;
  } frame_t;

  // one result
  typedef struct packed {
    logic [2:0]         door_state;
    cmd_t               door_command;
    fault_t             fault_code;
    pos_t               door_position;
    logic               locked;
    motor_t             motor_drive;
    logic               buzzer_on;
    logic [RETRY_W-1:0] retry_count;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/dss_if.sv =====
// request channels of the door safety state machine: frames, results, config writes
// depends on dss_pkg
`default_nettype none

interface dss_in_if;
  logic valid;
  logic ready;
  logic open_feedback;
  logic closed_feedback;
  logic lock_sense;
  logic reset_req;
  logic open_req;
  logic close_req;
  logic obstruction;

  modport source (output valid, open_feedback, closed_feedback, lock_sense, reset_req,
                  open_req, close_req, obstruction, input ready);
  modport sink   (input valid, open_feedback, closed_feedback, lock_sense, reset_req,
                  open_req, close_req, obstruction, output ready);
endinterface

interface dss_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  door_state;
  logic [2:0]                  door_command;
  logic [1:0]                  fault_code;
  logic [1:0]                  door_position;
  logic                        locked;
  logic [1:0]                  motor_drive;
  logic                        buzzer_on;
  logic [dss_pkg::RETRY_W-1:0] retry_count;

  modport source (output valid, door_state, door_command, fault_code, door_position,
                  locked, motor_drive, buzzer_on, retry_count, input ready);
  modport sink   (input valid, door_state, door_command, fault_code, door_position,
                  locked, motor_drive, buzzer_on, retry_count, output ready);
endinterface

interface dss_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dss_pkg::CFG_IDX_W-1:0] index;
  logic [dss_pkg::CFG_DAT_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/dss_cfg_regs.sv =====
// configuration registers: motion timeout and nudge retry limit
// depends on dss_pkg
`default_nettype none

module dss_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [dss_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [dss_pkg::CFG_DAT_W-1:0] wr_data,
  output dss_pkg::cfg_t                      cfg
);

  dss_pkg::cfg_t cfg_r;
  dss_pkg::cfg_t cfg_nxt;

  // decode the write request; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        dss_pkg::CFG_MOTION_TIMEOUT: begin
          cfg_nxt.motion_timeout_frames = wr_data[dss_pkg::TIMEOUT_W-1:0];
        end
        dss_pkg::CFG_NUDGE_LIMIT: begin
          cfg_nxt.nudge_retry_limit = wr_data[dss_pkg::RETRY_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_timeout_frames <= dss_pkg::TIMEOUT_RESET;
      cfg_r.nudge_retry_limit     <= dss_pkg::NUDGE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/dss_fsm.sv =====
// door state machine with fault latch, retry and motion counters, and result register
// depends on dss_pkg
`default_nettype none

module dss_fsm (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire dss_pkg::frame_t   frame,
  input  wire dss_pkg::cfg_t     cfg,
  output dss_pkg::result_t       res
);

  localparam int CW = dss_pkg::FRAME_COUNT_WIDTH;
  localparam logic [CW-1:0] COUNT_ONE = CW'(1);
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  typedef enum logic [2:0] {
    ST_CLOSED  = 3'd0,
    ST_OPENING = 3'd1,
    ST_OPEN    = 3'd2,
    ST_CLOSING = 3'd3,
    ST_NUDGE   = 3'd4,
    ST_FAULT   = 3'd5
  } state_t;

  state_t                      state_r, state_nxt;
  dss_pkg::fault_t             held_r, held_nxt;
  logic [dss_pkg::RETRY_W-1:0] retries_r, retries_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  dss_pkg::result_t            res_r, res_nxt;

  dss_pkg::pos_t   pos;
  dss_pkg::cmd_t   cmd;
  dss_pkg::fault_t flt;
  dss_pkg::motor_t motor;
  logic            timed_out;
  logic [CW-1:0]   count_inc;

  // position decode and timeout compare
  always_comb begin
    if (frame.open_feedback && !frame.closed_feedback) begin
      pos = dss_pkg::POS_OPEN;
    end else if (frame.closed_feedback && !frame.open_feedback) begin
      pos = dss_pkg::POS_CLOSED;
    end else begin
      pos = dss_pkg::POS_BETWEEN;
    end
  end

  assign timed_out = (33'(count_r) >= 33'(cfg.motion_timeout_frames));
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_ONE;

  // next state and command
  always_comb begin
    state_nxt   = state_r;
    held_nxt    = held_r;
    retries_nxt = retries_r;
    count_nxt   = count_r;
    cmd         = dss_pkg::CMD_LATCH_FAULT;
    flt         = dss_pkg::FLT_NONE;
    unique case (state_r)
      ST_CLOSED: begin
        if (frame.open_req) begin
          state_nxt = ST_OPENING;
          count_nxt = COUNT_ONE;
          cmd       = dss_pkg::CMD_DRIVE_OPEN;
        end else begin
          cmd = dss_pkg::CMD_HOLD_CLOSED;
        end
      end
      ST_OPENING: begin
        priority if (pos == dss_pkg::POS_OPEN) begin
          state_nxt = ST_OPEN;
          count_nxt = '0;
          cmd       = dss_pkg::CMD_HOLD_OPEN;
        end else if (timed_out) begin
          state_nxt = ST_FAULT;
          held_nxt  = dss_pkg::FLT_TIMEOUT;
          count_nxt = '0;
          cmd       = dss_pkg::CMD_LATCH_FAULT;
          flt       = dss_pkg::FLT_TIMEOUT;
        end else begin
          count_nxt = count_inc;
          cmd       = dss_pkg::CMD_DRIVE_OPEN;
        end
      end
      ST_OPEN: begin
        if (frame.close_req) begin
          count_nxt = COUNT_ONE;
          if (retries_r >= cfg.nudge_retry_limit) begin
            state_nxt = ST_NUDGE;
            cmd       = dss_pkg::CMD_NUDGE_CLOSE;
          end else begin
            state_nxt = ST_CLOSING;
            cmd       = dss_pkg::CMD_DRIVE_CLOSE;
          end
        end else begin
          cmd = dss_pkg::CMD_HOLD_OPEN;
        end
      end
      ST_CLOSING, ST_NUDGE: begin
        priority if (state_r == ST_CLOSING && frame.obstruction) begin
          // obstruction while closing: count a retry and reopen
          if (retries_r < dss_pkg::RETRY_MAX) begin
            retries_nxt = retries_r + 4'd1;
          end
          state_nxt = ST_OPENING;
          count_nxt = COUNT_ONE;
          cmd       = dss_pkg::CMD_DRIVE_OPEN;
        end else if (pos == dss_pkg::POS_CLOSED) begin
          count_nxt = '0;
          if (!frame.lock_sense) begin
            state_nxt = ST_FAULT;
            held_nxt  = dss_pkg::FLT_LOCK;
            cmd       = dss_pkg::CMD_LATCH_FAULT;
            flt       = dss_pkg::FLT_LOCK;
          end else begin
            state_nxt   = ST_CLOSED;
            retries_nxt = '0;
            cmd         = dss_pkg::CMD_HOLD_CLOSED;
          end
        end else if (timed_out) begin
          state_nxt = ST_FAULT;
          held_nxt  = dss_pkg::FLT_TIMEOUT;
          count_nxt = '0;
          cmd       = dss_pkg::CMD_LATCH_FAULT;
          flt       = dss_pkg::FLT_TIMEOUT;
        end else begin
          count_nxt = count_inc;
          cmd = (state_r == ST_NUDGE) ? dss_pkg::CMD_NUDGE_CLOSE : dss_pkg::CMD_DRIVE_CLOSE;
        end
      end
      default: begin
        // fault: leave only on reset request with door closed and locked
        state_nxt = ST_FAULT;
        if (frame.reset_req && pos == dss_pkg::POS_CLOSED && frame.lock_sense) begin
          state_nxt   = ST_CLOSED;
          held_nxt    = dss_pkg::FLT_NONE;
          retries_nxt = '0;
          count_nxt   = '0;
          cmd         = dss_pkg::CMD_RESET;
        end else begin
          cmd = dss_pkg::CMD_LATCH_FAULT;
          flt = held_r;
        end
      end
    endcase
  end

  // motor drive follows the updated state
  always_comb begin
    priority if (state_nxt == ST_OPENING) begin
      motor = dss_pkg::MOTOR_OPEN;
    end else if (state_nxt == ST_CLOSING || state_nxt == ST_NUDGE) begin
      motor = dss_pkg::MOTOR_CLOSE;
    end else begin
      motor = dss_pkg::MOTOR_STOP;
    end
  end

  // result assembly
  always_comb begin
    res_nxt.door_state    = state_nxt;
    res_nxt.door_command  = cmd;
    res_nxt.fault_code    = flt;
    res_nxt.door_position = pos;
    res_nxt.locked        = frame.lock_sense;
    res_nxt.motor_drive   = motor;
    res_nxt.buzzer_on     = (state_nxt == ST_NUDGE) || (state_nxt == ST_FAULT);
    res_nxt.retry_count   = retries_nxt;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLOSED;
      held_r    <= dss_pkg::FLT_NONE;
      retries_r <= '0;
      count_r   <= '0;
    end else if (step) begin
      state_r   <= state_nxt;
      held_r    <= held_nxt;
      retries_r <= retries_nxt;
      count_r   <= count_nxt;
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== rtl/door_safety_state_machine.sv =====
// Door safety state machine. Takes one control frame per cycle while its input is ready
// and returns one result per frame. A frame is captured in an input register, runs
// through the door state update and lands in a result register, where it is offered
// until it is taken; the state update loop sets a sustained rate of one frame per
// clock while results are taken, and a stalled result holds off new requests once
// the input register is full. Configuration writes are always ready and apply to
// every frame whose state update comes after them.
// depends on dss_pkg, dss_if, dss_cfg_regs, dss_fsm and the assertion macro header
`default_nettype none

`include "door_safety_state_machine_assert.svh"

module door_safety_state_machine (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dss_in_if.sink     in_chan,
  dss_out_if.source  out_chan,
  dss_cfg_if.sink    cfg_chan
);

  dss_pkg::cfg_t    cfg;
  dss_pkg::frame_t  frame_r, frame_nxt;
  dss_pkg::result_t res;
  logic             in_vld_r, in_vld_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             advance;
  logic             in_take;
  logic             fault_shown;
  logic             latch_shown;
  logic             reset_shown;
  logic             retries_clear;

  // configuration port
  assign cfg_chan.ready = 1'b1;

  dss_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.wdata),
    .cfg      (cfg)
  );

  // handshake control: frame moves on when the result register is free or drains
  assign advance       = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    frame_nxt.open_feedback   = in_chan.open_feedback;
    frame_nxt.closed_feedback = in_chan.closed_feedback;
    frame_nxt.lock_sense      = in_chan.lock_sense;
    frame_nxt.reset_req       = in_chan.reset_req;
    frame_nxt.open_req        = in_chan.open_req;
    frame_nxt.close_req       = in_chan.close_req;
    frame_nxt.obstruction     = in_chan.obstruction;
  end

  always_comb begin
    in_vld_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_r);
    out_vld_nxt = advance ? 1'b1 : (out_chan.ready ? 1'b0 : out_vld_r);
  end

  // input register and valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (in_take) begin
      frame_r <= frame_nxt;
    end
  end

  dss_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .frame (frame_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result channel
  assign out_chan.valid         = out_vld_r;
  assign out_chan.door_state    = res.door_state;
  assign out_chan.door_command  = res.door_command;
  assign out_chan.fault_code    = res.fault_code;
  assign out_chan.door_position = res.door_position;
  assign out_chan.locked        = res.locked;
  assign out_chan.motor_drive   = res.motor_drive;
  assign out_chan.buzzer_on     = res.buzzer_on;
  assign out_chan.retry_count   = res.retry_count;

  // terms for the checks
  assign fault_shown   = out_vld_r && (out_chan.fault_code != dss_pkg::FLT_NONE);
  assign latch_shown   = (out_chan.door_command == dss_pkg::CMD_LATCH_FAULT);
  assign reset_shown   = out_vld_r && (out_chan.door_command == dss_pkg::CMD_RESET);
  assign retries_clear = (out_chan.retry_count == '0) && !out_chan.buzzer_on;

  // checks
  `DSS_ASSERT_NEXT(a_stalled_frame_kept, clk, rst_n, in_vld_r && !advance, in_vld_r)
  `DSS_ASSERT_IMPL(a_fault_only_on_latch, clk, rst_n, fault_shown, latch_shown)
  `DSS_ASSERT_IMPL(a_reset_clears_retries, clk, rst_n, reset_shown, retries_clear)

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for door_safety_state_machine: a short directed frame table, then
// random frame sequences over several register settings; uses dss_pkg, dss_if and the DUT
module testbench;

  typedef enum logic [2:0] {
    DOOR_CLOSED  = 3'd0,
    DOOR_OPENING = 3'd1,
    DOOR_OPEN    = 3'd2,
    DOOR_CLOSING = 3'd3,
    DOOR_NUDGE   = 3'd4,
    DOOR_FAULT   = 3'd5
  } door_mode_t;

  // one directed step; want is only used where typed is set
  typedef struct packed {
    dss_pkg::frame_t  frame;
    logic             typed;
    dss_pkg::result_t want;
  } step_row_t;

  localparam int N_DIRECTED = 25;
  localparam int N_PHASES = 8;
  localparam int FRAMES_PER_PHASE = 200;

  // frame bits: open_fb closed_fb lock reset_req open_req close_req obstruction
  localparam step_row_t DIRECTED_STEPS[N_DIRECTED] = '{
    '{frame: 7'b0110000, typed: 1'b1,
      want: '{door_state: DOOR_CLOSED, door_command: dss_pkg::CMD_HOLD_CLOSED,
              fault_code: dss_pkg::FLT_NONE, door_position: dss_pkg::POS_CLOSED,
              locked: 1'b1, motor_drive: dss_pkg::MOTOR_STOP,
              buzzer_on: 1'b0, retry_count: 4'd0}},
    '{frame: 7'b1111111, typed: 1'b1,
      want: '{door_state: DOOR_OPENING, door_command: dss_pkg::CMD_DRIVE_OPEN,
              fault_code: dss_pkg::FLT_NONE, door_position: dss_pkg::POS_BETWEEN,
              locked: 1'b1, motor_drive: dss_pkg::MOTOR_OPEN,
              buzzer_on: 1'b0, retry_count: 4'd0}},
    '{frame: 7'b0001010, typed: 1'b0, want: '0},
    '{frame: 7'b1000000, typed: 1'b0, want: '0},
    '{frame: 7'b1000101, typed: 1'b0, want: '0},
    '{frame: 7'b1000010, typed: 1'b0, want: '0},
    '{frame: 7'b0000001, typed: 1'b0, want: '0},
    '{frame: 7'b1000000, typed: 1'b0, want: '0},
    '{frame: 7'b1000010, typed: 1'b0, want: '0},
    '{frame: 7'b0000001, typed: 1'b0, want: '0},
    '{frame: 7'b1000000, typed: 1'b0, want: '0},
    '{frame: 7'b1000010, typed: 1'b0, want: '0},
    '{frame: 7'b0000001, typed: 1'b0, want: '0},
    '{frame: 7'b1000000, typed: 1'b0, want: '0},
    '{frame: 7'b1000010, typed: 1'b0, want: '0},
    '{frame: 7'b0000001, typed: 1'b0, want: '0},
    '{frame: 7'b0100000, typed: 1'b1,
      want: '{door_state: DOOR_FAULT, door_command: dss_pkg::CMD_LATCH_FAULT,
              fault_code: dss_pkg::FLT_LOCK, door_position: dss_pkg::POS_CLOSED,
              locked: 1'b0, motor_drive: dss_pkg::MOTOR_STOP,
              buzzer_on: 1'b1, retry_count: 4'd3}},
    '{frame: 7'b0101000, typed: 1'b1,
      want: '{door_state: DOOR_FAULT, door_command: dss_pkg::CMD_LATCH_FAULT,
              fault_code: dss_pkg::FLT_LOCK, door_position: dss_pkg::POS_CLOSED,
              locked: 1'b0, motor_drive: dss_pkg::MOTOR_STOP,
              buzzer_on: 1'b1, retry_count: 4'd3}},
    '{frame: 7'b1111000, typed: 1'b0, want: '0},
    '{frame: 7'b0111000, typed: 1'b1,
      want: '{door_state: DOOR_CLOSED, door_command: dss_pkg::CMD_RESET,
              fault_code: dss_pkg::FLT_NONE, door_position: dss_pkg::POS_CLOSED,
              locked: 1'b1, motor_drive: dss_pkg::MOTOR_STOP,
              buzzer_on: 1'b0, retry_count: 4'd0}},
    '{frame: 7'b0010100, typed: 1'b0, want: '0},
    '{frame: 7'b1100000, typed: 1'b0, want: '0},
    '{frame: 7'b1010000, typed: 1'b0, want: '0},
    '{frame: 7'b1010010, typed: 1'b0, want: '0},
    '{frame: 7'b0110000, typed: 1'b0, want: '0}
  };

  // register settings of the first phases, the extremes among them
  localparam logic [15:0] PHASE_TIMEOUT[5] = '{16'd0, 16'd1, 16'hFFFF, 16'd3, 16'd2};
  localparam logic [15:0] PHASE_NUDGE[5] = '{16'd0, 16'd1, 16'd15, 16'd2, 16'd15};

  logic clk;
  logic rst_n;

  dss_in_if  in_chan ();
  dss_out_if out_chan ();
  dss_cfg_if cfg_chan ();

  door_safety_state_machine u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // predicted door state and register copies
  door_mode_t       door_mode;
  dss_pkg::fault_t  held_fault;
  logic [3:0]       retries_q;
  logic [15:0]      move_cnt;
  logic [15:0]      timeout_lim;
  logic [3:0]       nudge_lim;

  dss_pkg::result_t door_results_due[$];
  int               mismatch_count;
  bit               src_steady;
  bit               snk_steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic void trip_fault(dss_pkg::fault_t code);
    door_mode = DOOR_FAULT;
    held_fault = code;
    move_cnt = 16'd0;
  endfunction

  function automatic void count_motion();
    if (move_cnt != 16'hFFFF) move_cnt = move_cnt + 16'd1;
  endfunction

  // advance the door model by one frame and return its result
  function automatic dss_pkg::result_t predict_door_frame(dss_pkg::frame_t f);
    dss_pkg::result_t r;
    dss_pkg::pos_t    pos;
    dss_pkg::cmd_t    cmd;
    dss_pkg::fault_t  flt;
    logic             timed_out;
    logic             use_nudge;
    pos = (f.open_feedback && !f.closed_feedback) ? dss_pkg::POS_OPEN :
          ((f.closed_feedback && !f.open_feedback) ? dss_pkg::POS_CLOSED :
           dss_pkg::POS_BETWEEN);
    cmd = dss_pkg::CMD_HOLD_CLOSED;
    flt = dss_pkg::FLT_NONE;
    timed_out = move_cnt >= timeout_lim;
    case (door_mode)
      DOOR_CLOSED: begin
        if (f.open_req) begin
          door_mode = DOOR_OPENING;
          move_cnt = 16'd1;
          cmd = dss_pkg::CMD_DRIVE_OPEN;
        end
      end
      DOOR_OPENING: begin
        if (pos == dss_pkg::POS_OPEN) begin
          door_mode = DOOR_OPEN;
          move_cnt = 16'd0;
          cmd = dss_pkg::CMD_HOLD_OPEN;
        end else if (timed_out) begin
          trip_fault(dss_pkg::FLT_TIMEOUT);
          cmd = dss_pkg::CMD_LATCH_FAULT;
          flt = dss_pkg::FLT_TIMEOUT;
        end else begin
          count_motion();
          cmd = dss_pkg::CMD_DRIVE_OPEN;
        end
      end
      DOOR_OPEN: begin
        cmd = dss_pkg::CMD_HOLD_OPEN;
        if (f.close_req) begin
          use_nudge = retries_q >= nudge_lim;
          door_mode = use_nudge ? DOOR_NUDGE : DOOR_CLOSING;
          move_cnt = 16'd1;
          cmd = use_nudge ? dss_pkg::CMD_NUDGE_CLOSE : dss_pkg::CMD_DRIVE_CLOSE;
        end
      end
      DOOR_CLOSING, DOOR_NUDGE: begin
        // obstruction reopens a normal close only; nudge pushes through
        if (door_mode == DOOR_CLOSING && f.obstruction) begin
          if (retries_q != 4'd15) retries_q = retries_q + 4'd1;
          door_mode = DOOR_OPENING;
          move_cnt = 16'd1;
          cmd = dss_pkg::CMD_DRIVE_OPEN;
        end else if (pos == dss_pkg::POS_CLOSED) begin
          move_cnt = 16'd0;
          if (!f.lock_sense) begin
            trip_fault(dss_pkg::FLT_LOCK);
            cmd = dss_pkg::CMD_LATCH_FAULT;
            flt = dss_pkg::FLT_LOCK;
          end else begin
            door_mode = DOOR_CLOSED;
            retries_q = 4'd0;
          end
        end else if (timed_out) begin
          trip_fault(dss_pkg::FLT_TIMEOUT);
          cmd = dss_pkg::CMD_LATCH_FAULT;
          flt = dss_pkg::FLT_TIMEOUT;
        end else begin
          count_motion();
          cmd = (door_mode == DOOR_NUDGE) ? dss_pkg::CMD_NUDGE_CLOSE :
                                            dss_pkg::CMD_DRIVE_CLOSE;
        end
      end
      default: begin
        // fault clears only when closed, locked and asked to
        door_mode = DOOR_FAULT;
        if (f.reset_req && pos == dss_pkg::POS_CLOSED && f.lock_sense) begin
          door_mode = DOOR_CLOSED;
          held_fault = dss_pkg::FLT_NONE;
          retries_q = 4'd0;
          move_cnt = 16'd0;
          cmd = dss_pkg::CMD_RESET;
        end else begin
          cmd = dss_pkg::CMD_LATCH_FAULT;
          flt = held_fault;
        end
      end
    endcase
    r.door_state = door_mode;
    r.door_command = cmd;
    r.fault_code = flt;
    r.door_position = pos;
    r.locked = f.lock_sense;
    if (door_mode == DOOR_OPENING) r.motor_drive = dss_pkg::MOTOR_OPEN;
    else if (door_mode == DOOR_CLOSING || door_mode == DOOR_NUDGE)
      r.motor_drive = dss_pkg::MOTOR_CLOSE;
    else r.motor_drive = dss_pkg::MOTOR_STOP;
    r.buzzer_on = (door_mode == DOOR_NUDGE || door_mode == DOOR_FAULT);
    r.retry_count = retries_q;
    return r;
  endfunction

  // random frame, mostly shaped to move the door along from its current state
  function automatic dss_pkg::frame_t make_frame(int obst_pct);
    dss_pkg::frame_t f;
    f = dss_pkg::frame_t'(7'($urandom_range(0, 127)));
    if (chance(10)) return f;
    case (door_mode)
      DOOR_CLOSED: begin
        f.open_req = chance(50);
        {f.open_feedback, f.closed_feedback} = chance(70) ? 2'b01 : 2'($urandom_range(0, 3));
      end
      DOOR_OPENING: begin
        {f.open_feedback, f.closed_feedback} = chance(35) ? 2'b10 :
                                               (chance(50) ? 2'b00 : 2'b11);
      end
      DOOR_OPEN: begin
        f.close_req = chance(40);
        {f.open_feedback, f.closed_feedback} = chance(70) ? 2'b10 : 2'($urandom_range(0, 3));
      end
      DOOR_CLOSING, DOOR_NUDGE: begin
        f.obstruction = chance(obst_pct);
        f.lock_sense = chance(85);
        {f.open_feedback, f.closed_feedback} = chance(30) ? 2'b01 :
                                               (chance(50) ? 2'b00 : 2'b11);
      end
      default: begin
        f.reset_req = chance(60);
        f.lock_sense = chance(80);
        {f.open_feedback, f.closed_feedback} = chance(70) ? 2'b01 : 2'($urandom_range(0, 3));
      end
    endcase
    return f;
  endfunction

  // present one frame request after a random gap and log its expected result
  task automatic send_frame(dss_pkg::frame_t f, logic typed, dss_pkg::result_t want);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 14);
    repeat (gap) @(negedge clk);
    in_chan.open_feedback = f.open_feedback;
    in_chan.closed_feedback = f.closed_feedback;
    in_chan.lock_sense = f.lock_sense;
    in_chan.reset_req = f.reset_req;
    in_chan.open_req = f.open_req;
    in_chan.close_req = f.close_req;
    in_chan.obstruction = f.obstruction;
    in_chan.valid = 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (typed) begin
      void'(predict_door_frame(f));
      door_results_due.push_back(want);
    end else begin
      door_results_due.push_back(predict_door_frame(f));
    end
    @(negedge clk);
    in_chan.valid = 1'b0;
  endtask

  task automatic write_reg(logic [dss_pkg::CFG_IDX_W-1:0] idx,
                           logic [dss_pkg::CFG_DAT_W-1:0] data);
    cfg_chan.index = idx;
    cfg_chan.wdata = data;
    cfg_chan.valid = 1'b1;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    if (idx == dss_pkg::CFG_MOTION_TIMEOUT) timeout_lim = data;
    else if (idx == dss_pkg::CFG_NUDGE_LIMIT) nudge_lim = data[3:0];
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (door_results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(string field, logic [3:0] want_v, logic [3:0] got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch in %s: expected %0d, got %0d", field, want_v, got_v);
    end
  endtask

  // result side: random stalls, compare each accepted result with the oldest prediction
  initial begin
    int               stall_left;
    dss_pkg::result_t want;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_chan.ready = 1'b0;
      end else if (stall_left > 0) begin
        out_chan.ready = 1'b0;
        stall_left--;
      end else begin
        out_chan.ready = 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (door_results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("result with no frame pending");
        end else begin
          want = door_results_due.pop_front();
          check_field("door_state", 4'(want.door_state), 4'(out_chan.door_state));
          check_field("door_command", 4'(want.door_command), 4'(out_chan.door_command));
          check_field("fault_code", 4'(want.fault_code), 4'(out_chan.fault_code));
          check_field("door_position", 4'(want.door_position), 4'(out_chan.door_position));
          check_field("locked", 4'(want.locked), 4'(out_chan.locked));
          check_field("motor_drive", 4'(want.motor_drive), 4'(out_chan.motor_drive));
          check_field("buzzer_on", 4'(want.buzzer_on), 4'(out_chan.buzzer_on));
          check_field("retry_count", want.retry_count, out_chan.retry_count);
        end
        stall_left = snk_steady ? 0 : $urandom_range(0, 14);
      end
    end
  end

  // main sequence
  initial begin
    int obst_pct;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.open_feedback = 1'b0;
    in_chan.closed_feedback = 1'b0;
    in_chan.lock_sense = 1'b0;
    in_chan.reset_req = 1'b0;
    in_chan.open_req = 1'b0;
    in_chan.close_req = 1'b0;
    in_chan.obstruction = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = dss_pkg::CFG_MOTION_TIMEOUT;
    cfg_chan.wdata = '0;
    mismatch_count = 0;
    src_steady = 1'b0;
    snk_steady = 1'b0;
    door_mode = DOOR_CLOSED;
    held_fault = dss_pkg::FLT_NONE;
    retries_q = 4'd0;
    move_cnt = 16'd0;
    timeout_lim = dss_pkg::TIMEOUT_RESET;
    nudge_lim = dss_pkg::NUDGE_RESET;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed walk with reset register values
    for (int i = 0; i < N_DIRECTED; i++)
      send_frame(DIRECTED_STEPS[i].frame, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);

    // random phases, registers rewritten only once idle
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      if (p < 5) begin
        write_reg(dss_pkg::CFG_MOTION_TIMEOUT, PHASE_TIMEOUT[p]);
        write_reg(dss_pkg::CFG_NUDGE_LIMIT, PHASE_NUDGE[p]);
      end else begin
        write_reg(dss_pkg::CFG_NUDGE_LIMIT, 16'($urandom_range(0, 15)));
        write_reg(dss_pkg::CFG_MOTION_TIMEOUT, 16'($urandom_range(1, 30)));
      end
      // heavy obstruction phases build up retries toward nudge
      obst_pct = (p % 3 == 2 || p == 4) ? 70 : 15;
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        if (n % 50 == 0) begin
          src_steady = chance(25);
          snk_steady = chance(25);
        end
        send_frame(make_frame(obst_pct), 1'b0, '0);
      end
    end

    while (door_results_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dss_pkg.sv
rtl/dss_if.sv
rtl/dss_cfg_regs.sv
rtl/dss_fsm.sv
rtl/door_safety_state_machine.sv
tb/sv/testbench.sv
